// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the deframer project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define DCPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("dcpd assertion failed");

// clocked assertion that also holds during reset
`define DCPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dcpd assertion failed");

`endif

// ===== src/dcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcpd_pkg
// shared constants, codes and beat types of the dual copy packet deframer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcpd_pkg;

  // packet geometry
  localparam int HEADER_LEN     = 6;
  localparam int DATASET_BYTES  = 48;
  localparam int COUNTER_OFFSET = 4;
  localparam int STORE_DEPTH    = 2 * DATASET_BYTES;

  // derived widths
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int IDX_W     = $clog2(DATASET_BYTES);
  localparam int POS_W     = $clog2(HEADER_LEN + STORE_DEPTH + 1);
  localparam int HDR_REGS  = 6;
  localparam int HDR_IDX_W = 3;
  localparam int CNT_W     = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // result kinds
  typedef enum logic [1:0] {
    KIND_TEXT     = 2'd0,
    KIND_DATA     = 2'd1,
    KIND_HDR_ERR  = 2'd2,
    KIND_BOTH_BAD = 2'd3
  } kind_e;

  // command from front to back
  typedef struct packed {
    kind_e                    kind;
    logic [7:0]               data;
    logic                     copy;
    logic                     differ;
    logic                     csdiff;
    logic                     aok;
    logic                     gap;
    logic signed [CNT_W-1:0]  missed;
  } cmd_t;

  // one result beat
  typedef struct packed {
    kind_e                    kind;
    logic [7:0]               data;
    logic                     last;
    logic                     copy;
    logic                     differ;
    logic                     csdiff;
    logic                     aok;
    logic                     gap;
    logic signed [CNT_W-1:0]  missed;
  } res_t;

  // status from back to front
  typedef struct packed {
    logic stream_done;
    logic streaming;
  } back_stat_t;

endpackage

// ===== src/dcpd_buf.sv =====
// ----------------------------------------------------------------------------
// dcpd_buf
// packet store: one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcpd_buf (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [dcpd_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [dcpd_pkg::ADDR_W-1:0] ra_addr_i,
  output logic [7:0]                ra_data_o,
  input  logic [dcpd_pkg::ADDR_W-1:0] rb_addr_i,
  output logic [7:0]                rb_data_o
);
  import dcpd_pkg::*;

  logic [7:0] mem_q [STORE_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

// ===== src/dcpd_queue.sv =====
// ----------------------------------------------------------------------------
// dcpd_queue
// short command fifo between the classifying front and the output back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcpd_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output dcpd_pkg::cmd_t head_o,
  output logic           empty_o
);
  import dcpd_pkg::*;

  cmd_t              ent_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/dcpd_front.sv =====
// ----------------------------------------------------------------------------
// dcpd_front
// accepts received bytes, tracks header and copies, issues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcpd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [7:0]                  cfg_data_i,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  // packet store
  output logic                        we_o,
  output logic [dcpd_pkg::ADDR_W-1:0] waddr_o,
  output logic [7:0]                  wdata_o,
  output logic [dcpd_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                  rdata_i,
  // command queue
  output logic                        push_o,
  output dcpd_pkg::cmd_t              cmd_o,
  input  logic                        full_i,
  // back status
  input  dcpd_pkg::back_stat_t        stat_i
);
  import dcpd_pkg::*;

  localparam logic FS_IN   = 1'b0;
  localparam logic FS_PROC = 1'b1;

  logic             fs_q, fs_d;
  logic [7:0]       hdr_q [HDR_REGS];
  logic [7:0]       byte_q;
  logic             recv_q, recv_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             hm_q, hm_d;
  logic [7:0]       xa_q, xa_d;
  logic [7:0]       xb_q, xb_d;
  logic             mm_q, mm_d;
  logic [7:0]       csa_q, csa_d;
  logic [CNT_W-1:0] cnta_q, cnta_d;
  logic [CNT_W-1:0] cntb_q, cntb_d;
  logic [CNT_W-1:0] exp_q, exp_d;
  logic             pend_q, pend_d;

  logic             accept;
  logic             data_phase;
  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] np;
  logic             is_text;
  logic             in_hdr;
  logic [ADDR_W-1:0] d_addr;
  logic [7:0]       hdr_sel;
  logic             hm_new;
  logic             a_ok;
  logic             b_ok;
  logic             finish;
  logic [CNT_W-1:0] cnt_sel;
  logic             push_req;
  logic             go;

  // store read address for the copy compare, taken from the held position
  assign raddr_o = ADDR_W'(pos_q - POS_W'(HEADER_LEN) - POS_W'(DATASET_BYTES));

  // stall while busy, or in the data phase while the store still holds a packet being streamed
  assign data_phase = recv_q && (pos_q >= POS_W'(HEADER_LEN));
  assign in_stall_o = !((fs_q == FS_IN) && !(data_phase && (pend_q || stat_i.streaming)));
  assign accept     = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HDR_REGS; i++) begin
        hdr_q[i] <= 8'h00;
      end
    end else if (cfg_we_i && (cfg_idx_i < HDR_IDX_W'(HDR_REGS))) begin
      hdr_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // classification of the held byte
  always_comb begin
    pos_eff = recv_q ? pos_q : '0;
    np      = pos_eff + 1'b1;
    is_text = !recv_q && (byte_q != hdr_q[0]);
    in_hdr  = (pos_eff < POS_W'(HEADER_LEN));
    d_addr  = ADDR_W'(pos_eff - POS_W'(HEADER_LEN));
    hdr_sel = in_hdr ? hdr_q[HDR_IDX_W'(pos_eff)] : 8'h00;
    hm_new  = hm_q && (!in_hdr || (byte_q == hdr_sel));
    finish  = !in_hdr && (np == POS_W'(HEADER_LEN + STORE_DEPTH));
  end

  // running checksums, compare flag and counter capture
  always_comb begin
    xa_d   = xa_q;
    xb_d   = xb_q;
    mm_d   = mm_q;
    csa_d  = csa_q;
    cnta_d = cnta_q;
    cntb_d = cntb_q;
    if (!in_hdr) begin
      if (d_addr < ADDR_W'(DATASET_BYTES)) begin
        if (d_addr < ADDR_W'(DATASET_BYTES - 1)) begin
          xa_d = xa_q ^ byte_q;
        end else begin
          csa_d = byte_q;
        end
      end else begin
        if (d_addr < ADDR_W'(STORE_DEPTH - 1)) begin
          xb_d = xb_q ^ byte_q;
        end
        if (rdata_i != byte_q) begin
          mm_d = 1'b1;
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (COUNTER_OFFSET + i < DATASET_BYTES) begin
          if (d_addr == ADDR_W'(COUNTER_OFFSET + i)) begin
            cnta_d[8*i +: 8] = byte_q;
          end
          if (d_addr == ADDR_W'(DATASET_BYTES + COUNTER_OFFSET + i)) begin
            cntb_d[8*i +: 8] = byte_q;
          end
        end
      end
    end
  end

  // end of packet decision
  assign a_ok    = (xa_q == csa_q);
  assign b_ok    = (xb_q == byte_q);
  assign cnt_sel = a_ok ? cnta_q : cntb_d;

  // command build
  always_comb begin
    cmd_o        = '0;
    push_req     = 1'b0;
    cmd_o.kind   = KIND_TEXT;
    if (fs_q == FS_PROC) begin
      if (is_text) begin
        push_req   = 1'b1;
        cmd_o.data = byte_q;
      end else if (in_hdr && (np == POS_W'(HEADER_LEN)) && !hm_new) begin
        push_req   = 1'b1;
        cmd_o.kind = KIND_HDR_ERR;
      end else if (finish) begin
        push_req     = 1'b1;
        cmd_o.differ = mm_d;
        cmd_o.csdiff = (csa_q != byte_q);
        cmd_o.aok    = a_ok;
        if (!a_ok && !b_ok) begin
          cmd_o.kind = KIND_BOTH_BAD;
        end else begin
          cmd_o.kind   = KIND_DATA;
          cmd_o.copy   = !a_ok;
          cmd_o.missed = cnt_sel - exp_q;
          cmd_o.gap    = (cnt_sel != exp_q);
        end
      end
    end
  end

  // a command enters the queue only when there is room
  assign push_o = push_req && !full_i;
  assign go     = (fs_q == FS_PROC) && (!push_req || !full_i);

  // packet store write
  assign we_o    = go && !is_text && !in_hdr;
  assign waddr_o = d_addr;
  assign wdata_o = byte_q;

  // packet state update
  always_comb begin
    fs_d   = fs_q;
    recv_d = recv_q;
    pos_d  = pos_q;
    hm_d   = hm_q;
    exp_d  = exp_q;
    pend_d = pend_q;
    if (stat_i.stream_done) begin
      pend_d = 1'b0;
    end
    if ((fs_q == FS_IN) && accept) begin
      fs_d = FS_PROC;
    end
    if (go) begin
      fs_d = FS_IN;
      if (!is_text) begin
        if (push_o) begin
          recv_d = 1'b0;
          pos_d  = '0;
          hm_d   = 1'b1;
          if (cmd_o.kind == KIND_DATA) begin
            exp_d  = cnt_sel + 1'b1;
            pend_d = 1'b1;
          end
        end else begin
          recv_d = 1'b1;
          pos_d  = np;
          hm_d   = hm_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FS_IN;
      recv_q <= 1'b0;
      pos_q  <= '0;
      hm_q   <= 1'b1;
      xa_q   <= 8'h00;
      xb_q   <= 8'h00;
      mm_q   <= 1'b0;
      csa_q  <= 8'h00;
      cnta_q <= '0;
      cntb_q <= '0;
      exp_q  <= CNT_W'(1);
      pend_q <= 1'b0;
    end else begin
      fs_q   <= fs_d;
      recv_q <= recv_d;
      pos_q  <= pos_d;
      hm_q   <= hm_d;
      exp_q  <= exp_d;
      pend_q <= pend_d;
      if (go && !is_text) begin
        if (push_o) begin
          xa_q <= 8'h00;
          xb_q <= 8'h00;
          mm_q <= 1'b0;
        end else begin
          xa_q <= xa_d;
          xb_q <= xb_d;
          mm_q <= mm_d;
        end
        csa_q  <= csa_d;
        cnta_q <= cnta_d;
        cntb_q <= cntb_d;
      end
    end
  end

  // input byte hold
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

// ===== src/dcpd_back.sv =====
// ----------------------------------------------------------------------------
// dcpd_back
// pops commands and drives the result channel, streaming the chosen copy
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcpd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command queue
  input  dcpd_pkg::cmd_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  // packet store
  output logic [dcpd_pkg::ADDR_W-1:0] raddr_o,
  input  logic [7:0]                  rdata_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output dcpd_pkg::res_t              res_o,
  // status to front
  output dcpd_pkg::back_stat_t        stat_o
);
  import dcpd_pkg::*;

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_RD   = 2'd1;
  localparam logic [1:0] BS_EMIT = 2'd2;

  logic [1:0]       bs_q, bs_d;
  cmd_t             cmd_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             oval_q, oval_d;
  res_t             res_q, res_d;
  logic             slot_free;
  logic             load;
  logic             last_byte;

  assign slot_free = !oval_q || !out_stall_i;
  assign last_byte = (idx_q == IDX_W'(DATASET_BYTES - 1));
  assign raddr_o   = cmd_q.copy ? (ADDR_W'(DATASET_BYTES) + ADDR_W'(idx_q)) : ADDR_W'(idx_q);

  // sequencer
  always_comb begin
    bs_d   = bs_q;
    idx_d  = idx_q;
    pop_o  = 1'b0;
    load   = 1'b0;
    res_d  = res_q;
    stat_o = '0;
    stat_o.streaming = (bs_q != BS_IDLE);
    case (bs_q)
      BS_IDLE: begin
        if (!empty_i && slot_free) begin
          pop_o = 1'b1;
          if (head_i.kind == KIND_DATA) begin
            idx_d = '0;
            bs_d  = BS_RD;
          end else begin
            load         = 1'b1;
            res_d        = '0;
            res_d.kind   = head_i.kind;
            res_d.data   = head_i.data;
            res_d.last   = 1'b1;
            res_d.differ = head_i.differ;
            res_d.csdiff = head_i.csdiff;
            res_d.aok    = head_i.aok;
          end
        end
      end
      BS_RD: begin
        bs_d = BS_EMIT;
      end
      BS_EMIT: begin
        if (slot_free) begin
          load         = 1'b1;
          res_d.kind   = KIND_DATA;
          res_d.data   = rdata_i;
          res_d.last   = last_byte;
          res_d.copy   = cmd_q.copy;
          res_d.differ = cmd_q.differ;
          res_d.csdiff = cmd_q.csdiff;
          res_d.aok    = cmd_q.aok;
          res_d.gap    = cmd_q.gap;
          res_d.missed = cmd_q.missed;
          if (last_byte) begin
            bs_d = BS_IDLE;
            stat_o.stream_done = 1'b1;
          end else begin
            idx_d = idx_q + 1'b1;
            bs_d  = BS_RD;
          end
        end
      end
      default: begin
        bs_d = BS_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    oval_d = oval_q;
    if (load) begin
      oval_d = 1'b1;
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q   <= BS_IDLE;
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      bs_q   <= bs_d;
      idx_q  <= idx_d;
      oval_q <= oval_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == KIND_DATA)) begin
      cmd_q <= head_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = oval_q;
  assign res_o       = res_q;

endmodule

// ===== src/dual_copy_packet_deframer_top.sv =====
// ----------------------------------------------------------------------------
// dual_copy_packet_deframer_top
// deframer for serial packets carrying two copies of an xor-checked dataset
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat on rx_byte_i (in_valid_i/in_stall_o).
// Result channel: one result per beat (out_valid_o/out_stall_i): text bytes,
// header errors, both-checksums-bad reports and the bytes of the chosen copy.
// Configuration: cfg_we_i writes header byte cfg_idx_i (0..5) with cfg_data_i.
// In the front each input byte is first accepted, then classified against a
// registered store read; a text byte or error then goes through the command
// queue to the output register of the back.
// At the end of a packet the chosen copy streams out byte by byte: the back
// waits on its registered store read port, then hands each byte to the output
// register once it is free. The next packet's header is taken while the copy
// drains; its first data byte waits until the last dataset byte is in that register.
// A 4-entry command queue separates front and back; a stalled receiver fills
// it and then holds in_stall_o high. Results are never dropped.
// Reset clears header registers, packet state and the expected counter
// (last counter 0); no clearing pass of the store is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_copy_packet_deframer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               copy_used_o,
  output logic               copies_differ_o,
  output logic               checksum_bytes_differ_o,
  output logic               checksum_a_ok_o,
  output logic               counter_gap_o,
  output logic signed [31:0] missed_count_o
);
  import dcpd_pkg::*;

  logic              st_we;
  logic [ADDR_W-1:0] st_waddr;
  logic [7:0]        st_wdata;
  logic [ADDR_W-1:0] st_ra_addr;
  logic [7:0]        st_ra_data;
  logic [ADDR_W-1:0] st_rb_addr;
  logic [7:0]        st_rb_data;
  logic              q_push;
  cmd_t              q_in;
  logic              q_full;
  logic              q_pop;
  cmd_t              q_head;
  logic              q_empty;
  back_stat_t        back_stat;
  res_t              res;

  // front: byte intake and packet tracking
  dcpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .we_o       (st_we),
    .waddr_o    (st_waddr),
    .wdata_o    (st_wdata),
    .raddr_o    (st_ra_addr),
    .rdata_i    (st_ra_data),
    .push_o     (q_push),
    .cmd_o      (q_in),
    .full_i     (q_full),
    .stat_i     (back_stat)
  );

  // packet store
  dcpd_buf u_buf (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (st_waddr),
    .wdata_i   (st_wdata),
    .ra_addr_i (st_ra_addr),
    .ra_data_o (st_ra_data),
    .rb_addr_i (st_rb_addr),
    .rb_data_o (st_rb_data)
  );

  // command queue
  dcpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // back: result output and dataset streaming
  dcpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .raddr_o     (st_rb_addr),
    .rdata_i     (st_rb_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .stat_o      (back_stat)
  );

  // result fields
  assign kind_o                  = res.kind;
  assign out_byte_o              = res.data;
  assign last_o                  = res.last;
  assign copy_used_o             = res.copy;
  assign copies_differ_o         = res.differ;
  assign checksum_bytes_differ_o = res.csdiff;
  assign checksum_a_ok_o         = res.aok;
  assign counter_gap_o           = res.gap;
  assign missed_count_o          = res.missed;

  // checks
  `DCPD_ASSERT(a_no_push_full, clk_i, rst_ni, q_push |-> !q_full)
  `DCPD_ASSERT(a_no_pop_empty, clk_i, rst_ni, q_pop |-> !q_empty)
  `DCPD_ASSERT(a_single_is_last, clk_i, rst_ni, (out_valid_o && (kind_o != KIND_DATA)) |-> last_o)
  `DCPD_ASSERT_ALWAYS(a_done_ends_stream, clk_i, back_stat.stream_done |=> !back_stat.stream_done)

endmodule

// ===== sim/dcpd_result_checker.sv =====
// ----------------------------------------------------------------------------
// dcpd_result_checker
// watches the byte, configuration and result channels of the deframer,
// predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcpd_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         out_byte_i,
  input  logic               last_i,
  input  logic               copy_used_i,
  input  logic               copies_differ_i,
  input  logic               checksum_bytes_differ_i,
  input  logic               checksum_a_ok_i,
  input  logic               counter_gap_i,
  input  logic signed [31:0] missed_count_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  import dcpd_pkg::*;

  // predicted deframer state
  logic [7:0]  hdr_exp [HDR_REGS];
  logic        in_packet;
  int          pkt_pos;
  logic        hdr_seen_ok;
  logic [7:0]  pkt_store [STORE_DEPTH];
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic        copies_split;
  logic [31:0] prev_counter;

  res_t        expected_beats [$];
  res_t        oldest;
  int          mismatches = 0;

  // one-beat result, marked last, with every other flag cleared
  function automatic res_t plain_beat(input kind_e k, input logic [7:0] b);
    res_t r;
    r      = '0;
    r.kind = k;
    r.data = b;
    r.last = 1'b1;
    return r;
  endfunction

  // back to waiting for a start marker; the counter history stays
  function automatic void drop_packet();
    in_packet    = 1'b0;
    pkt_pos      = 0;
    hdr_seen_ok  = 1'b1;
    sum_a        = '0;
    sum_b        = '0;
    copies_split = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) pkt_store[k] = '0;
  endfunction

  // pick a copy by its checksum and queue the dataset beats, or one both-bad beat if neither checksum holds
  function automatic void release_packet();
    logic [7:0]  cs_a;
    logic [7:0]  cs_b;
    logic        a_ok;
    logic        b_ok;
    logic        use_b;
    logic [31:0] cnt;
    logic [31:0] want_cnt;
    int          base;
    res_t        r;
    cs_a = pkt_store[DATASET_BYTES - 1];
    cs_b = pkt_store[STORE_DEPTH - 1];
    a_ok = (sum_a == cs_a);
    b_ok = (sum_b == cs_b);
    if (!a_ok && !b_ok) begin
      r        = plain_beat(KIND_BOTH_BAD, 8'h00);
      r.differ = copies_split;
      r.csdiff = (cs_a != cs_b);
      expected_beats.push_back(r);
    end else begin
      use_b = !a_ok;
      base  = use_b ? DATASET_BYTES : 0;
      cnt   = '0;
      // counter bytes past the dataset read as zero
      for (int i = 0; i < 4; i++) begin
        if (COUNTER_OFFSET + i < DATASET_BYTES) begin
          cnt[8*i +: 8] = pkt_store[base + COUNTER_OFFSET + i];
        end
      end
      want_cnt     = prev_counter + 32'd1;
      prev_counter = cnt;
      for (int i = 0; i < DATASET_BYTES; i++) begin
        r        = plain_beat(KIND_DATA, pkt_store[base + i]);
        r.last   = (i == DATASET_BYTES - 1);
        r.copy   = use_b;
        r.differ = copies_split;
        r.csdiff = (cs_a != cs_b);
        r.aok    = a_ok;
        r.gap    = (cnt != want_cnt);
        r.missed = cnt - want_cnt;
        expected_beats.push_back(r);
      end
    end
    drop_packet();
  endfunction

  // advance the prediction by one received byte
  function automatic void absorb_byte(input logic [7:0] c);
    int d;
    if (!in_packet) begin
      if (c != hdr_exp[0]) begin
        expected_beats.push_back(plain_beat(KIND_TEXT, c));
        return;
      end
      in_packet = 1'b1;
      pkt_pos   = 0;
    end
    if (pkt_pos < HEADER_LEN) begin
      if (c != hdr_exp[pkt_pos]) hdr_seen_ok = 1'b0;
    end else begin
      d            = pkt_pos - HEADER_LEN;
      pkt_store[d] = c;
      if (d < DATASET_BYTES) begin
        if (d < DATASET_BYTES - 1) sum_a ^= c;
      end else begin
        if (d - DATASET_BYTES < DATASET_BYTES - 1) sum_b ^= c;
        if (pkt_store[d - DATASET_BYTES] != c) copies_split = 1'b1;
      end
    end
    pkt_pos++;
    // a bad header is only reported once all of it is in
    if (pkt_pos == HEADER_LEN) begin
      if (!hdr_seen_ok) begin
        expected_beats.push_back(plain_beat(KIND_HDR_ERR, 8'h00));
        drop_packet();
      end
    end else if (pkt_pos == HEADER_LEN + STORE_DEPTH) begin
      release_packet();
    end
  endfunction

  task automatic check_field(input string nm, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
      mismatches++;
    end
  endtask

  // compare finished beats first, then fold in config and the new byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HDR_REGS; k++) hdr_exp[k] = '0;
      drop_packet();
      prev_counter = '0;
      expected_beats.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat mismatch, expected none, actual kind %0d byte %0h",
                   $time, kind_i, out_byte_i);
          mismatches++;
        end else begin
          oldest = expected_beats.pop_front();
          check_field("kind", oldest.kind, kind_i);
          check_field("out_byte", oldest.data, out_byte_i);
          check_field("last", oldest.last, last_i);
          check_field("copy_used", oldest.copy, copy_used_i);
          check_field("copies_differ", oldest.differ, copies_differ_i);
          check_field("checksum_bytes_differ", oldest.csdiff, checksum_bytes_differ_i);
          check_field("checksum_a_ok", oldest.aok, checksum_a_ok_i);
          check_field("counter_gap", oldest.gap, counter_gap_i);
          check_field("missed_count", oldest.missed, missed_count_i);
        end
      end
      if (cfg_we_i && cfg_idx_i < HDR_REGS) hdr_exp[cfg_idx_i] = cfg_data_i;
      if (in_valid_i && !in_stall_i) absorb_byte(rx_byte_i);
      mismatches_o <= mismatches;
      pending_o    <= expected_beats.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives the deframer with text, broken headers and a dual-copy packet under
// several header settings, with random gaps and output stalls; the checker
// beside the block predicts the results and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import dcpd_pkg::*;

  typedef enum int {
    PKT_CLEAN,
    PKT_A_BAD,
    PKT_BOTH_BAD,
    PKT_GAP,
    PKT_B_BAD,
    PKT_BOTH_VALID_SPLIT
  } pkt_mode_e;

  typedef logic [7:0] copy_t [DATASET_BYTES];

  localparam int NUM_MODES     = 6;
  localparam int IDLE_PCT      = 26;
  localparam int SETTLE_CYCLES = 8;
  // first byte that may be flipped without touching the counter
  localparam int FREE_FIRST    = COUNTER_OFFSET + 4;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [7:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [7:0]         out_byte;
  logic               last;
  logic               copy_used;
  logic               copies_differ;
  logic               cs_differ;
  logic               a_ok;
  logic               counter_gap;
  logic signed [31:0] missed_count;
  int                 mismatches;
  int                 pending;

  logic               quiet;
  logic [7:0]         hdr_val [HDR_REGS];
  logic [31:0]        run_counter;

  dual_copy_packet_deframer_top dut (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .cfg_we_i                (cfg_we),
    .cfg_idx_i               (cfg_idx),
    .cfg_data_i              (cfg_data),
    .in_valid_i              (in_valid),
    .in_stall_o              (in_stall),
    .rx_byte_i               (rx_byte),
    .out_valid_o             (out_valid),
    .out_stall_i             (out_stall),
    .kind_o                  (kind),
    .out_byte_o              (out_byte),
    .last_o                  (last),
    .copy_used_o             (copy_used),
    .copies_differ_o         (copies_differ),
    .checksum_bytes_differ_o (cs_differ),
    .checksum_a_ok_o         (a_ok),
    .counter_gap_o           (counter_gap),
    .missed_count_o          (missed_count)
  );

  dcpd_result_checker result_check (
    .clk_i                   (clk),
    .rst_ni                  (rst_n),
    .cfg_we_i                (cfg_we),
    .cfg_idx_i               (cfg_idx),
    .cfg_data_i              (cfg_data),
    .in_valid_i              (in_valid),
    .in_stall_i              (in_stall),
    .rx_byte_i               (rx_byte),
    .out_valid_i             (out_valid),
    .out_stall_i             (out_stall),
    .kind_i                  (kind),
    .out_byte_i              (out_byte),
    .last_i                  (last),
    .copy_used_i             (copy_used),
    .copies_differ_i         (copies_differ),
    .checksum_bytes_differ_i (cs_differ),
    .checksum_a_ok_i         (a_ok),
    .counter_gap_i           (counter_gap),
    .missed_count_i          (missed_count),
    .mismatches_o            (mismatches),
    .pending_o               (pending)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random receiver stalls, none while quiet
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // hard stop for a hung run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one beat on the byte channel, with an optional random gap in front
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending until every predicted beat is out, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all header registers plus the unused indexes above them
  task automatic program_header();
    for (int k = 0; k < 8; k++) begin
      cfg_we  <= 1'b1;
      cfg_idx <= 3'(k);
      if (k < HDR_REGS) cfg_data <= hdr_val[k];
      else cfg_data <= 8'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_header(input bit spoil);
    int         bad_at;
    logic [7:0] flip;
    bad_at = $urandom_range(HEADER_LEN - 1, 1);
    flip   = 8'($urandom_range(255, 1));
    for (int k = 0; k < HEADER_LEN; k++) begin
      send_byte((spoil && k == bad_at) ? (hdr_val[k] ^ flip) : hdr_val[k]);
    end
  endtask

  // text never carries the start marker
  task automatic send_text(input int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == hdr_val[0]);
      send_byte(b);
    end
  endtask

  // set the last byte to the xor of the others
  function automatic copy_t sealed(input copy_t d);
    logic [7:0] x;
    x = '0;
    for (int k = 0; k < DATASET_BYTES - 1; k++) x ^= d[k];
    d[DATASET_BYTES - 1] = x;
    return d;
  endfunction

  // break the checksum, through a data byte or the checksum byte itself
  function automatic copy_t spoiled(input copy_t d);
    logic [7:0] flip;
    flip = 8'($urandom_range(255, 1));
    if ($urandom_range(3) == 0) d[DATASET_BYTES - 1] ^= flip;
    else d[$urandom_range(DATASET_BYTES - 2, FREE_FIRST)] ^= flip;
    return d;
  endfunction

  task automatic send_packet(input pkt_mode_e mode);
    copy_t       copy_a;
    copy_t       copy_b;
    logic [31:0] cnt;
    logic [31:0] jump;
    cnt = run_counter + 32'd1;
    // gaps at the signed extremes, a full wrap or anything
    if (mode == PKT_GAP) begin
      case ($urandom_range(3))
        0:       jump = 32'h7fff_ffff;
        1:       jump = 32'h8000_0000;
        2:       jump = 32'hffff_ffff;
        default: jump = $urandom;
      endcase
      cnt += jump;
    end
    for (int k = 0; k < DATASET_BYTES; k++) copy_a[k] = 8'($urandom);
    for (int k = 0; k < 4; k++) copy_a[COUNTER_OFFSET + k] = cnt[8*k +: 8];
    // the start marker inside a packet is plain data
    if ($urandom_range(1)) copy_a[$urandom_range(DATASET_BYTES - 2, FREE_FIRST)] = hdr_val[0];
    copy_a = sealed(copy_a);
    copy_b = copy_a;
    case (mode)
      PKT_A_BAD:    copy_a = spoiled(copy_a);
      PKT_BOTH_BAD: begin
        copy_a = spoiled(copy_a);
        copy_b = spoiled(copy_b);
      end
      PKT_B_BAD:    copy_b = spoiled(copy_b);
      PKT_BOTH_VALID_SPLIT: begin
        copy_b[$urandom_range(DATASET_BYTES - 2, FREE_FIRST)] ^= 8'($urandom_range(255, 1));
        copy_b = sealed(copy_b);
      end
      default: ;
    endcase
    if (mode != PKT_BOTH_BAD) run_counter = cnt;
    send_header(1'b0);
    foreach (copy_a[k]) send_byte(copy_a[k]);
    foreach (copy_b[k]) send_byte(copy_b[k]);
  endtask

  initial begin
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    quiet    <= 1'b0;
    for (int k = 0; k < HDR_REGS; k++) hdr_val[k] = '0;
    run_counter = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset header is all zero: text extremes pass, a zero byte opens a packet
    send_byte(8'hff);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'h01);
    // header mismatch in the last position, then in the second
    repeat (HEADER_LEN - 1) send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'hff);
    repeat (HEADER_LEN - 2) send_byte(8'h00);
    send_byte(8'hfe);
    settle();

    // mixed header with gaps: text around a broken header
    hdr_val = '{8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'h0f, 8'hf0};
    program_header();
    send_text(5);
    send_header(1'b1);
    send_text(3);
    settle();

    // all-ones header with no gaps or stalls at all: a packet of any kind,
    // then text and a broken header queued behind the dataset stream
    quiet <= 1'b1;
    for (int k = 0; k < HDR_REGS; k++) hdr_val[k] = 8'hff;
    program_header();
    send_packet(pkt_mode_e'($urandom_range(NUM_MODES - 1)));
    send_text(3);
    send_header(1'b1);
    settle();
    quiet <= 1'b0;

    // random header
    for (int k = 0; k < HDR_REGS; k++) hdr_val[k] = 8'($urandom);
    program_header();
    send_text(4);
    send_header(1'b1);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
